/* hw/rtl/reversible_deque_engine_defines.svh */
// Assertion macros shared by the deque engine RTL.
`ifndef REVERSIBLE_DEQUE_ENGINE_DEFINES_SVH
`define REVERSIBLE_DEQUE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rde same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rde next-cycle check failed");

`endif

/* hw/rtl/rde_pkg.sv */
package rde_pkg;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 16;
	localparam int ITEM_W   = 16;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ELEM  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

endpackage

/* hw/rtl/rde_ram.sv */
module rde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/reversible_deque_engine.sv */
// Channel  | Transfer edge         | Signals
// ---------+-----------------------+-------------------------------
// command  | start && !busy        | start, busy, command, value
// result   | strobe (one cycle)    | strobe, item, status, last
//
// Clear, push, toggle, delete and unused codes leave busy low.
// A drain of N stored elements holds busy while it reads them, one store read a cycle;
// each result appears in the cycle after its read (the RAM read is registered).
// A marker drain (error or empty list) keeps busy low; its result comes next cycle.
// Reset clears pointers, count and flags; the element store is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
`include "reversible_deque_engine_defines.svh"

module reversible_deque_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rde_pkg::CMD_W-1:0]      command,
	input  logic [rde_pkg::VALUE_W-1:0]    value,
	output logic                           strobe,
	output logic [rde_pkg::ITEM_W-1:0]     item,
	output logic [rde_pkg::STATUS_W-1:0]   status,
	output logic                           last
);

	import rde_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

	typedef enum logic {
		IDLE,
		DRAIN
	} state_t;

	state_t state_q;

	// architectural state outside the element store
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             rev_q;
	logic             err_q;

	// drain sequencer
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] rem_q;
	logic             dir_rev_q;

	// result path: elem_v_s1 marks RAM read data that is an element
	logic                elem_v_s1;
	logic                last_s1;
	logic                mark_v_q;
	logic [STATUS_W-1:0] mark_status_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] push_slot;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] addr_next;
	logic             ram_we;
	logic             ram_re;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// ring index a + b, both below DEPTH, with one compare-subtract wrap
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[IDX_W-1:0];
	endfunction

	assign busy   = (state_q == DRAIN);
	assign accept = start && !busy;
	assign full   = (count_q == FULL_C);
	assign empty  = (count_q == '0);

	// the truncated operands are below DEPTH wherever these are used, so the truncations are exact
	assign push_slot = wrap_add(head_q, IDX_W'(count_q));
	assign tail_slot = wrap_add(head_q, IDX_W'(count_q - 1'b1));
	assign head_next = wrap_add(head_q, IDX_W'(1));

	// next read address of a drain: forward walks up, reversed walks down
	always_comb begin
		if (dir_rev_q) begin
			addr_next = (addr_q == '0) ? LAST_IX : addr_q - 1'b1;
		end else begin
			addr_next = (addr_q == LAST_IX) ? '0 : addr_q + 1'b1;
		end
	end

	assign ram_we = accept && (command == CMD_PUSH) && !full;
	assign ram_re = (state_q == DRAIN);

	rde_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (push_slot),
		.wdata (DATA_WIDTH'(value)),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			head_q        <= '0;
			count_q       <= '0;
			rev_q         <= 1'b0;
			err_q         <= 1'b0;
			addr_q        <= '0;
			rem_q         <= '0;
			dir_rev_q     <= 1'b0;
			elem_v_s1     <= 1'b0;
			last_s1       <= 1'b0;
			mark_v_q      <= 1'b0;
			mark_status_q <= ST_ELEM;
		end else begin
			case (state_q)
				IDLE: begin
					elem_v_s1 <= 1'b0;
					mark_v_q  <= accept && (command == CMD_DRAIN) && (err_q || empty);
					if (accept) begin
						case (command)
							CMD_CLEAR: begin
								head_q  <= '0;
								count_q <= '0;
								rev_q   <= 1'b0;
								err_q   <= 1'b0;
							end
							CMD_PUSH: begin
								if (full) begin
									err_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_TOGGLE: begin
								rev_q <= !rev_q;
							end
							CMD_DELETE: begin
								if (empty) begin
									err_q <= 1'b1;
								end else begin
									if (!rev_q) begin
										head_q <= head_next;
									end
									count_q <= count_q - 1'b1;
								end
							end
							CMD_DRAIN: begin
								if (err_q || empty) begin
									mark_status_q <= err_q ? ST_ERROR : ST_EMPTY;
								end else begin
									// snapshot the walk, then the queue is fresh
									state_q   <= DRAIN;
									addr_q    <= rev_q ? tail_slot : head_q;
									rem_q     <= count_q;
									dir_rev_q <= rev_q;
								end
								head_q  <= '0;
								count_q <= '0;
								rev_q   <= 1'b0;
								err_q   <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				DRAIN: begin
					elem_v_s1 <= 1'b1;
					mark_v_q  <= 1'b0;
					last_s1   <= (rem_q == CNT_W'(1));
					addr_q    <= addr_next;
					rem_q     <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q   <= IDLE;
					elem_v_s1 <= 1'b0;
					mark_v_q  <= 1'b0;
				end
			endcase
		end
	end

	assign strobe = elem_v_s1 || mark_v_q;
	assign item   = mark_v_q ? '0 : ITEM_W'(ram_rdata);
	assign status = mark_v_q ? mark_status_q : ST_ELEM;
	assign last   = mark_v_q || last_s1;

	`RDE_ASSERT_NOW(a_no_result_overlap, clk, arst_n, elem_v_s1, !mark_v_q)
	`RDE_ASSERT_NOW(a_drain_has_work, clk, arst_n, state_q == DRAIN, rem_q != '0)
	`RDE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_C)
	`RDE_ASSERT_NOW(a_head_bound, clk, arst_n, 1'b1, {1'b0, head_q} < DEPTH_X)
	`RDE_ASSERT_NEXT(a_drain_goes_busy, clk, arst_n,
		accept && command == CMD_DRAIN && !err_q && !empty, busy && !mark_v_q)

endmodule
